// File: rtl/hrfd_pkg.sv
// Shared types, codes and constants for the HTTP/1 response framing decider.
package hrfd_pkg;

    typedef enum logic [1:0] {
        OP_BEGIN  = 2'd0,
        OP_HEADER = 2'd1,
        OP_BYTE   = 2'd2,
        OP_DECIDE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        CAUSE_NONE        = 3'd0,
        CAUSE_BAD_STATUS  = 3'd1,
        CAUSE_BOTH        = 3'd2,
        CAUSE_REPEAT_LEN  = 3'd3,
        CAUSE_REPEAT_ENC  = 3'd4,
        CAUSE_BAD_ENC     = 3'd5,
        CAUSE_BAD_LEN     = 3'd6
    } cause_t;

    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_CHUNKED = 2'd1,
        KIND_LENGTH  = 2'd2,
        KIND_CLOSE   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        TRIM_LEAD  = 3'b001,
        TRIM_IN    = 3'b010,
        TRIM_TRAIL = 3'b100
    } trim_t;

    localparam logic       HDR_LENGTH   = 1'b0;
    localparam logic       HDR_ENCODING = 1'b1;
    localparam logic [2:0] TOKEN_LEN    = 3'd7;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_TAB     = 8'h09;

    localparam logic [9:0] STATUS_MIN        = 10'd100;
    localparam logic [9:0] STATUS_INFO_MAX   = 10'd199;
    localparam logic [9:0] STATUS_NO_CONTENT = 10'd204;
    localparam logic [9:0] STATUS_NOT_MOD    = 10'd304;
    localparam logic [9:0] STATUS_MAX        = 10'd599;

    typedef struct packed {
        logic [1:0] operation;
        logic [9:0] status_code;
        logic       is_head;
        logic       header_select;
        logic [7:0] value_byte;
    } in_t;

    typedef struct packed {
        logic        result_code;
        logic [2:0]  error_cause;
        logic [1:0]  frame_kind;
        logic [63:0] body_length;
        logic        poolable;
    } out_t;

    // Commands from the top level to the value parser
    typedef struct packed {
        logic clear_len;
        logic clear_enc;
        logic take_byte;
        logic header;
    } hrfd_ctl_t;

    // Parse status seen by the decide logic
    typedef struct packed {
        logic [63:0] len_value;
        logic        len_seen;
        logic        len_invalid;
        logic [2:0]  enc_pos;
        logic        enc_mismatch;
    } hrfd_parse_t;

    function automatic logic [7:0] token_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h63; // c
            3'd1:    c = 8'h68; // h
            3'd2:    c = 8'h75; // u
            3'd3:    c = 8'h6E; // n
            3'd4:    c = 8'h6B; // k
            3'd5:    c = 8'h65; // e
            3'd6:    c = 8'h64; // d
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/http_response_framing_decider.sv
// Top level of the HTTP/1 response body framing decider.
// Takes one beat per clock: begin-response, begin-header and value-byte beats each
// update the header state in the cycle they are accepted, and a decide beat puts its
// result in the output register, shown in the cycle after acceptance. s_ready is low
// only while a result sits in that register and m_ready is low, so with a free sink
// the block sustains one beat per cycle. The per-byte Content-Length step (multiply
// by ten and add, with an overflow check) is the longest path.
module http_response_framing_decider
    import hrfd_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    logic [9:0]  status_reg, status_next;
    logic        head_reg, head_next;
    logic [1:0]  len_count_reg, len_count_next;
    logic [1:0]  enc_count_reg, enc_count_next;
    logic        cur_header_reg, cur_header_next;
    logic        m_valid_reg, m_valid_next;
    out_t        m_data_reg, m_data_next;

    logic        accept;
    op_t         op;
    hrfd_ctl_t   ctl;
    hrfd_parse_t parse;
    logic        has_len;
    logic        has_enc;
    logic        bodyless;
    cause_t      cause;
    out_t        decision;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign op      = op_t'(s_data.operation);

    always_comb begin
        ctl.clear_len = accept && ((op == OP_BEGIN) ||
                        (op == OP_HEADER && s_data.header_select == HDR_LENGTH));
        ctl.clear_enc = accept && ((op == OP_BEGIN) ||
                        (op == OP_HEADER && s_data.header_select == HDR_ENCODING));
        ctl.take_byte = accept && (op == OP_BYTE);
        ctl.header    = cur_header_reg;
    end

    hrfd_value_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (ctl),
        .value_byte (s_data.value_byte),
        .parse      (parse)
    );

    always_comb begin
        status_next     = status_reg;
        head_next       = head_reg;
        len_count_next  = len_count_reg;
        enc_count_next  = enc_count_reg;
        cur_header_next = cur_header_reg;
        if (accept) begin
            case (op)
                OP_BEGIN: begin
                    status_next     = s_data.status_code;
                    head_next       = s_data.is_head;
                    len_count_next  = 2'd0;
                    enc_count_next  = 2'd0;
                    cur_header_next = HDR_LENGTH;
                end
                OP_HEADER: begin
                    cur_header_next = s_data.header_select;
                    // count saturates at two
                    if (s_data.header_select == HDR_ENCODING) begin
                        if (enc_count_reg != 2'd2) begin
                            enc_count_next = enc_count_reg + 2'd1;
                        end
                    end else if (len_count_reg != 2'd2) begin
                        len_count_next = len_count_reg + 2'd1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign has_len  = len_count_reg != 2'd0;
    assign has_enc  = enc_count_reg != 2'd0;
    assign bodyless = (status_reg inside {[STATUS_MIN:STATUS_INFO_MAX]}) ||
                      status_reg == STATUS_NO_CONTENT || status_reg == STATUS_NOT_MOD;

    always_comb begin
        if (!(status_reg inside {[STATUS_MIN:STATUS_MAX]})) begin
            cause = CAUSE_BAD_STATUS;
        end else if (has_len && has_enc) begin
            cause = CAUSE_BOTH;
        end else if (len_count_reg == 2'd2) begin
            cause = CAUSE_REPEAT_LEN;
        end else if (enc_count_reg == 2'd2) begin
            cause = CAUSE_REPEAT_ENC;
        end else if (has_enc && (parse.enc_mismatch || parse.enc_pos != TOKEN_LEN)) begin
            cause = CAUSE_BAD_ENC;
        end else if (has_len && (parse.len_invalid || !parse.len_seen)) begin
            cause = CAUSE_BAD_LEN;
        end else begin
            cause = CAUSE_NONE;
        end
    end

    always_comb begin
        decision.result_code = (cause != CAUSE_NONE);
        decision.error_cause = cause;
        decision.frame_kind  = KIND_NONE;
        decision.body_length = 64'd0;
        decision.poolable    = 1'b1;
        if (cause == CAUSE_NONE) begin
            if (head_reg || bodyless) begin
                decision.frame_kind = KIND_NONE;
            end else if (has_enc) begin
                decision.frame_kind = KIND_CHUNKED;
            end else if (has_len) begin
                decision.frame_kind  = KIND_LENGTH;
                decision.body_length = parse.len_value;
            end else begin
                decision.frame_kind = KIND_CLOSE;
                decision.poolable   = 1'b0;
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (accept && op == OP_DECIDE) begin
            m_valid_next = 1'b1;
            m_data_next  = decision;
        end else if (m_ready) begin
            // drop the beat once the sink takes it
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg     <= 10'd0;
            head_reg       <= 1'b0;
            len_count_reg  <= 2'd0;
            enc_count_reg  <= 2'd0;
            cur_header_reg <= HDR_LENGTH;
            m_valid_reg    <= 1'b0;
        end else begin
            status_reg     <= status_next;
            head_reg       <= head_next;
            len_count_reg  <= len_count_next;
            enc_count_reg  <= enc_count_next;
            cur_header_reg <= cur_header_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: rtl/hrfd_value_parser.sv
// Header value parser: on-the-fly trimming, Content-Length decimal and chunked token match.
module hrfd_value_parser
    import hrfd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  hrfd_ctl_t   ctl,
    input  logic [7:0]  value_byte,
    output hrfd_parse_t parse
);

    trim_t       len_phase_reg, len_phase_next;
    trim_t       enc_phase_reg, enc_phase_next;
    logic [63:0] len_acc_reg, len_acc_next;
    logic        len_seen_reg, len_seen_next;
    logic        len_invalid_reg, len_invalid_next;
    logic [2:0]  enc_pos_reg, enc_pos_next;
    logic        enc_mismatch_reg, enc_mismatch_next;

    logic        is_ws;
    trim_t       phase;
    trim_t       phase_new;
    logic        take_char;
    logic        inner_ws;
    logic        is_digit;
    logic [67:0] acc_wide;
    logic [67:0] acc_prod;
    logic [7:0]  lower;
    logic [2:0]  pos_a;

    assign is_ws = (value_byte == CHAR_SPACE) || (value_byte == CHAR_TAB);
    assign phase = ctl.header ? enc_phase_reg : len_phase_reg;
    assign take_char = ctl.take_byte && !is_ws;
    // whitespace that turned out to be inside the value
    assign inner_ws = take_char && (phase == TRIM_TRAIL);

    always_comb begin
        phase_new = phase;
        if (is_ws) begin
            if (phase == TRIM_IN) begin
                phase_new = TRIM_TRAIL;
            end
        end else begin
            phase_new = TRIM_IN;
        end
    end

    // acc * 10 + digit, with four spare bits to catch overflow
    assign is_digit = value_byte inside {[8'h30:8'h39]};
    assign acc_wide = {4'b0000, len_acc_reg};
    assign acc_prod = (acc_wide << 3) + (acc_wide << 1) + {64'd0, value_byte[3:0]};

    assign lower = (value_byte inside {[8'h41:8'h5A]}) ? (value_byte | 8'h20) : value_byte;
    // the inner blank consumes one token position before the byte itself
    assign pos_a = (inner_ws && enc_pos_reg != TOKEN_LEN) ? enc_pos_reg + 3'd1 : enc_pos_reg;

    always_comb begin
        len_phase_next    = len_phase_reg;
        len_acc_next      = len_acc_reg;
        len_seen_next     = len_seen_reg;
        len_invalid_next  = len_invalid_reg;
        enc_phase_next    = enc_phase_reg;
        enc_pos_next      = enc_pos_reg;
        enc_mismatch_next = enc_mismatch_reg;

        if (ctl.clear_len) begin
            len_phase_next   = TRIM_LEAD;
            len_acc_next     = 64'd0;
            len_seen_next    = 1'b0;
            len_invalid_next = 1'b0;
        end else if (ctl.take_byte && ctl.header == HDR_LENGTH) begin
            len_phase_next = phase_new;
            if (take_char && !len_invalid_reg) begin
                if (inner_ws || !is_digit || acc_prod[67:64] != 4'd0) begin
                    len_invalid_next = 1'b1;
                end else begin
                    len_acc_next  = acc_prod[63:0];
                    len_seen_next = 1'b1;
                end
            end
        end

        if (ctl.clear_enc) begin
            enc_phase_next    = TRIM_LEAD;
            enc_pos_next      = 3'd0;
            enc_mismatch_next = 1'b0;
        end else if (ctl.take_byte && ctl.header == HDR_ENCODING) begin
            enc_phase_next = phase_new;
            if (take_char) begin
                if (pos_a == TOKEN_LEN) begin
                    enc_mismatch_next = 1'b1;
                end else begin
                    enc_pos_next = pos_a + 3'd1;
                    if (inner_ws || lower != token_char(pos_a)) begin
                        enc_mismatch_next = 1'b1;
                    end
                end
                if (inner_ws) begin
                    enc_mismatch_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_phase_reg    <= TRIM_LEAD;
            len_seen_reg     <= 1'b0;
            len_invalid_reg  <= 1'b0;
            enc_phase_reg    <= TRIM_LEAD;
            enc_pos_reg      <= 3'd0;
            enc_mismatch_reg <= 1'b0;
        end else begin
            len_phase_reg    <= len_phase_next;
            len_seen_reg     <= len_seen_next;
            len_invalid_reg  <= len_invalid_next;
            enc_phase_reg    <= enc_phase_next;
            enc_pos_reg      <= enc_pos_next;
            enc_mismatch_reg <= enc_mismatch_next;
        end
    end

    always_ff @(posedge aclk) begin
        len_acc_reg <= len_acc_next;
    end

    assign parse.len_value    = len_acc_reg;
    assign parse.len_seen     = len_seen_reg;
    assign parse.len_invalid  = len_invalid_reg;
    assign parse.enc_pos      = enc_pos_reg;
    assign parse.enc_mismatch = enc_mismatch_reg;

endmodule
